// ===== hw/rtl/piecewise_tone_mapper_assert.svh =====
// Assertion macros shared by the tone mapper RTL.
// Needs nothing else; included by the files that check their own logic.
`ifndef PIECEWISE_TONE_MAPPER_ASSERT_SVH
`define PIECEWISE_TONE_MAPPER_ASSERT_SVH

// same-cycle implication under reset
`define PTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tone mapper check failed");

// next-cycle implication under reset
`define PTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tone mapper check failed");

`endif

// ===== hw/rtl/ptm_pkg.sv =====
// Shared constants, types and curve tables of the piecewise tone mapper.
// No dependencies; used by every other RTL file but the assertion header.
package ptm_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned PIX_W         = 22;
  localparam int unsigned PEAK_W        = 14;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned LANES         = 3;
  localparam int unsigned DIV_STEPS     = PIX_W;
  localparam int unsigned DEN_SCALE     = 100;
  localparam int unsigned KNOTS         = 5;

  localparam logic [PIX_W-1:0]  PIX_MAX         = '1;
  localparam logic [PEAK_W-1:0] SRC_WHITE_RESET = 14'd1000;
  localparam logic [PEAK_W-1:0] DST_PEAK_RESET  = 14'd100;
  localparam logic [PEAK_W-1:0] MAX_CLL_RESET   = 14'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WHITE = 2'd0,
    CFG_DST_PEAK  = 2'd1,
    CFG_MAX_CLL   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic zero;
  } ptm_ctl_t;

  function automatic int unsigned curve_w(int unsigned f);
    int unsigned dw;
    dw = PEAK_W + f;
    return ((dw > PIX_W) ? dw : PIX_W) + 8;
  endfunction

  function automatic int unsigned ns_w(int unsigned f);
    return curve_w(f) + PEAK_W;
  endfunction

  function automatic int unsigned den_w(int unsigned f);
    return PIX_W + PEAK_W + 7 + f;
  endfunction

  function automatic logic [6:0] seg_base(logic [2:0] seg);
    logic [6:0] r;
    case (seg)
      3'd0:    r = 7'd0;
      3'd1:    r = 7'd75;
      3'd2:    r = 7'd85;
      3'd3:    r = 7'd90;
      3'd4:    r = 7'd93;
      default: r = 7'd95;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] seg_slope(logic [2:0] seg);
    logic [6:0] r;
    case (seg)
      3'd0:    r = 7'd75;
      3'd1:    r = 7'd10;
      3'd2:    r = 7'd5;
      3'd3:    r = 7'd3;
      3'd4:    r = 7'd2;
      default: r = 7'd1;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] seg_knot(logic [2:0] seg);
    logic [2:0] r;
    case (seg)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd3;
      3'd4:    r = 3'd4;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ptm_in_if.sv =====
// Input pixel channel: valid/ready handshake with three linear components.
// Depends on ptm_pkg for the component width.
interface ptm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ptm_pkg::PIX_W-1:0]  in_red;
  logic [ptm_pkg::PIX_W-1:0]  in_green;
  logic [ptm_pkg::PIX_W-1:0]  in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

// ===== hw/rtl/ptm_out_if.sv =====
// Output pixel channel: valid/ready handshake with three mapped components.
// Depends on ptm_pkg for the component width.
interface ptm_out_if;
  logic                       valid;
  logic                       ready;
  logic [ptm_pkg::PIX_W-1:0]  out_red;
  logic [ptm_pkg::PIX_W-1:0]  out_green;
  logic [ptm_pkg::PIX_W-1:0]  out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== hw/rtl/ptm_curve.sv =====
// Front pipeline: peak component, curve segment, curve numerator and divisor.
// Five register stages; depends on ptm_pkg.
module ptm_curve #(
  parameter int unsigned FracBits = ptm_pkg::FRACTION_BITS
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  logic [ptm_pkg::PIX_W-1:0]                 comp_i [ptm_pkg::LANES],
  input  logic [ptm_pkg::PEAK_W-1:0]                spw_i,
  input  logic [ptm_pkg::PEAK_W-1:0]                dpw_i,
  input  logic [ptm_pkg::PEAK_W-1:0]                sp_i,
  output ptm_pkg::ptm_ctl_t                         ctl_o,
  output logic [ptm_pkg::PIX_W-1:0]                 comp_o [ptm_pkg::LANES],
  output logic [ptm_pkg::ns_w(FracBits)-1:0]        ns_o,
  output logic [ptm_pkg::den_w(FracBits)-1:0]       den_o
);
  localparam int unsigned PW   = ptm_pkg::PIX_W;
  localparam int unsigned NL   = ptm_pkg::LANES;
  localparam int unsigned DW   = ptm_pkg::PEAK_W + FracBits;
  localparam int unsigned KDW  = DW + 3;
  localparam int unsigned NW   = ptm_pkg::curve_w(FracBits);
  localparam int unsigned NSW  = ptm_pkg::ns_w(FracBits);
  localparam int unsigned MSW  = PW + ptm_pkg::PEAK_W;
  localparam int unsigned DENW = ptm_pkg::den_w(FracBits);

  logic [DW-1:0] d;
  logic [PW-1:0] m;
  logic [2:0]    seg_d;

  ptm_pkg::ptm_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [PW-1:0]     c1_q [NL];
  logic [PW-1:0]     c2_q [NL];
  logic [PW-1:0]     c3_q [NL];
  logic [PW-1:0]     c4_q [NL];
  logic [PW-1:0]     c5_q [NL];
  logic [PW-1:0]     m1_q, m2_q;
  logic [2:0]        seg2_q, seg3_q;
  logic [PW-1:0]     off3_q;
  logic [MSW-1:0]    msp3_q;
  logic [NW-1:0]     n4_q;
  logic [DENW-1:0]   den4_q, den5_q;
  logic [NSW-1:0]    ns5_q;

  assign d = {dpw_i, FracBits'(0)};

  always_comb begin
    m = comp_i[0];
    if (comp_i[1] > m) m = comp_i[1];
    if (comp_i[2] > m) m = comp_i[2];
  end

  always_comb begin
    seg_d = 3'd0;
    for (int k = 1; k <= ptm_pkg::KNOTS; k++) begin
      if (KDW'(m1_q) > KDW'(d) * KDW'(k)) seg_d = seg_d + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{valid: valid_i, zero: 1'b0};
      ctl2_q <= '{valid: ctl1_q.valid, zero: (m1_q == '0)};
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= comp_i;
      m1_q   <= m;
      c2_q   <= c1_q;
      m2_q   <= m1_q;
      seg2_q <= seg_d;
      c3_q   <= c2_q;
      seg3_q <= seg2_q;
      off3_q <= PW'(KDW'(m2_q) - KDW'(ptm_pkg::seg_knot(seg2_q)) * KDW'(d));
      msp3_q <= MSW'(m2_q) * MSW'(sp_i);
      c4_q   <= c3_q;
      n4_q   <= NW'(ptm_pkg::seg_base(seg3_q)) * NW'(d)
              + NW'(ptm_pkg::seg_slope(seg3_q)) * NW'(off3_q);
      den4_q <= (DENW'(msp3_q) * DENW'(ptm_pkg::DEN_SCALE)) << FracBits;
      c5_q   <= c4_q;
      ns5_q  <= NSW'(n4_q) * NSW'(spw_i);
      den5_q <= den4_q;
    end
  end

  assign ctl_o  = ctl5_q;
  assign comp_o = c5_q;
  assign ns_o   = ns5_q;
  assign den_o  = den5_q;
endmodule

// ===== hw/rtl/ptm_div.sv =====
// Back pipeline: numerator product, saturation test and a restoring
// divider retiring one quotient bit per stage for all three lanes.
// Depends on ptm_pkg.
module ptm_div #(
  parameter int unsigned FracBits = ptm_pkg::FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  ptm_pkg::ptm_ctl_t                   ctl_i,
  input  logic [ptm_pkg::PIX_W-1:0]           comp_i [ptm_pkg::LANES],
  input  logic [ptm_pkg::ns_w(FracBits)-1:0]  ns_i,
  input  logic [ptm_pkg::den_w(FracBits)-1:0] den_i,
  output ptm_pkg::ptm_ctl_t                   ctl_o,
  output logic [ptm_pkg::PIX_W-1:0]           res_o [ptm_pkg::LANES]
);
  localparam int unsigned PW   = ptm_pkg::PIX_W;
  localparam int unsigned NL   = ptm_pkg::LANES;
  localparam int unsigned NS   = ptm_pkg::DIV_STEPS;
  localparam int unsigned NSW  = ptm_pkg::ns_w(FracBits);
  localparam int unsigned DENW = ptm_pkg::den_w(FracBits);
  localparam int unsigned LW   = (NSW + 1) / 2;
  localparam int unsigned HW   = NSW - LW;
  localparam int unsigned NUMW = PW + NSW;
  localparam int unsigned RW   = DENW + 1;
  localparam int unsigned CW   = (NSW > DENW) ? NSW : DENW;

  ptm_pkg::ptm_ctl_t ctl6_q, ctl7_q;
  logic [PW+LW-1:0]  plo_q [NL];
  logic [PW+HW-1:0]  phi_q [NL];
  logic [DENW-1:0]   den6_q, den7_q;
  logic [NUMW-1:0]   num_q [NL];

  ptm_pkg::ptm_ctl_t ctl_q [NS+1];
  logic [DENW-1:0]   den_q [NS+1];
  logic [RW-1:0]     rem_q [NS+1][NL];
  logic [PW-1:0]     lo_q  [NS+1][NL];
  logic [PW-1:0]     quo_q [NS+1][NL];
  logic              sat_q [NS+1][NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl6_q   <= '0;
      ctl7_q   <= '0;
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl6_q   <= ctl_i;
      ctl7_q   <= ctl6_q;
      ctl_q[0] <= ctl7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den6_q   <= den_i;
      den7_q   <= den6_q;
      den_q[0] <= den7_q;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [NSW-1:0] top;
    assign top = num_q[l][NUMW-1:PW];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[l]    <= (PW+LW)'(comp_i[l]) * (PW+LW)'(ns_i[LW-1:0]);
        phi_q[l]    <= (PW+HW)'(comp_i[l]) * (PW+HW)'(ns_i[NSW-1:LW]);
        num_q[l]    <= NUMW'(plo_q[l]) + (NUMW'(phi_q[l]) << LW);
        sat_q[0][l] <= (CW'(top) >= CW'(den7_q));
        rem_q[0][l] <= RW'(top);
        lo_q[0][l]  <= num_q[l][PW-1:0];
        quo_q[0][l] <= '0;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s+1] <= '0;
      end else if (en_i) begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [RW-1:0] trial;
      logic          fits;
      assign trial = {rem_q[s][l][RW-2:0], lo_q[s][l][PW-1]};
      assign fits  = (trial >= RW'(den_q[s]));

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1][l] <= fits ? (trial - RW'(den_q[s])) : trial;
          lo_q[s+1][l]  <= {lo_q[s][l][PW-2:0], 1'b0};
          quo_q[s+1][l] <= {quo_q[s][l][PW-2:0], fits};
          sat_q[s+1][l] <= sat_q[s][l];
        end
      end
    end
  end

  assign ctl_o = ctl_q[NS];

  for (genvar l = 0; l < NL; l++) begin : g_res
    assign res_o[l] = ctl_q[NS].zero ? '0
                    : (sat_q[NS][l] ? ptm_pkg::PIX_MAX : quo_q[NS][l]);
  end
endmodule

// ===== hw/rtl/piecewise_tone_mapper.sv =====
// Piecewise-linear HDR tone mapper, top level with peak registers and output skid.
// Input beats pass the curve pipeline, the divide pipeline and the output register to output valid.
// Throughput: one pixel per cycle while the skid register is empty; the 22-stage restoring divider sets the depth.
// Reset: asynchronous, active low; clears all valid bits, peaks to 1000/100/0.
// Depends on ptm_pkg, ptm_in_if, ptm_out_if, ptm_curve, ptm_div.
`include "piecewise_tone_mapper_assert.svh"
module piecewise_tone_mapper #(
  parameter int unsigned FracBits = ptm_pkg::FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptm_pkg::PEAK_W-1:0]        cfg_data_i,
  ptm_in_if.sink                            pix_i,
  ptm_out_if.source                         pix_o
);
  localparam int unsigned PW   = ptm_pkg::PIX_W;
  localparam int unsigned NL   = ptm_pkg::LANES;
  localparam int unsigned NSW  = ptm_pkg::ns_w(FracBits);
  localparam int unsigned DENW = ptm_pkg::den_w(FracBits);

  logic [ptm_pkg::PEAK_W-1:0] src_pw_q, dst_pw_q, max_cll_q;
  logic [ptm_pkg::PEAK_W-1:0] spw, dpw, sp;

  logic              en;
  logic [PW-1:0]     comp_in [NL];
  ptm_pkg::ptm_ctl_t ctl_mid, ctl_end;
  logic [PW-1:0]     comp_mid [NL];
  logic [NSW-1:0]    ns_mid;
  logic [DENW-1:0]   den_mid;
  logic [PW-1:0]     res [NL];

  logic              out_v_q, skid_v_q, out_free, out_stall;
  logic [PW-1:0]     out_q  [NL];
  logic [PW-1:0]     skid_q [NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_pw_q  <= ptm_pkg::SRC_WHITE_RESET;
      dst_pw_q  <= ptm_pkg::DST_PEAK_RESET;
      max_cll_q <= ptm_pkg::MAX_CLL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptm_pkg::CFG_SRC_WHITE: src_pw_q  <= cfg_data_i;
        ptm_pkg::CFG_DST_PEAK:  dst_pw_q  <= cfg_data_i;
        ptm_pkg::CFG_MAX_CLL:   max_cll_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign spw = (src_pw_q == '0) ? ptm_pkg::PEAK_W'(1) : src_pw_q;
  assign dpw = (dst_pw_q == '0) ? ptm_pkg::PEAK_W'(1) : dst_pw_q;
  assign sp  = (max_cll_q != '0) ? max_cll_q : spw;

  assign en          = !skid_v_q;
  assign pix_i.ready = en;
  assign comp_in[0]  = pix_i.in_red;
  assign comp_in[1]  = pix_i.in_green;
  assign comp_in[2]  = pix_i.in_blue;

  ptm_curve #(.FracBits(FracBits)) u_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .comp_i  (comp_in),
    .spw_i   (spw),
    .dpw_i   (dpw),
    .sp_i    (sp),
    .ctl_o   (ctl_mid),
    .comp_o  (comp_mid),
    .ns_o    (ns_mid),
    .den_o   (den_mid)
  );

  ptm_div #(.FracBits(FracBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_mid),
    .comp_i  (comp_mid),
    .ns_i    (ns_mid),
    .den_i   (den_mid),
    .ctl_o   (ctl_end),
    .res_o   (res)
  );

  assign out_stall = out_v_q && !pix_o.ready;
  assign out_free  = !out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || ctl_end.valid;
      skid_v_q <= 1'b0;
    end else if (ctl_end.valid && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (ctl_end.valid && en) begin
      skid_q <= res;
    end
  end

  assign pix_o.valid     = out_v_q;
  assign pix_o.out_red   = out_q[0];
  assign pix_o.out_green = out_q[1];
  assign pix_o.out_blue  = out_q[2];

  `PTM_ASSERT_IMPL(a_skid_needs_out, clk_i, rst_ni, skid_v_q, out_v_q)
  `PTM_ASSERT_NEXT(a_stalled_beat_parks, clk_i, rst_ni, out_stall && ctl_end.valid && en, skid_v_q)
  `PTM_ASSERT_IMPL(a_skid_from_stall, clk_i, rst_ni, $rose(skid_v_q), $past(out_stall))
endmodule
